// ----- design/dqsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dqsa_pkg
// Shared types and constants for the dual queue shared array unit.
// ----------------------------------------------------------------------------
package dqsa_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SHOW = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

// ----- design/dqsa_if.sv -----
// ----------------------------------------------------------------------------
// dqsa_if
// Request and response channels (valid/ready) of the dual queue unit.
// ----------------------------------------------------------------------------
interface dqsa_req_if import dqsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic                     queue_select;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, queue_select, value, input ready);
  modport sink (input valid, operation, queue_select, value, output ready);
  modport monitor (input valid, ready, operation, queue_select, value);
endinterface

interface dqsa_rsp_if import dqsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  modport source (output valid, status, data, last, input ready);
  modport sink (input valid, status, data, last, output ready);
  modport monitor (input valid, ready, status, data, last);
endinterface

// ----- design/dual_queue_shared_array_unit.sv -----
// ----------------------------------------------------------------------------
// dual_queue_shared_array_unit
// Two queues in one word store: A grows up from index 0, B down from the top.
// ----------------------------------------------------------------------------
// One request is handled at a time. For enqueue, dequeue and any error result
// the transfer cycle issues the head read on the single memory read port; the
// execute state then, once the result register is free, decides, writes the
// store and loads the result register. A display reads its entries one per
// cycle through the read port while the response side does not stall.
// The result register frees the request side: the next request transfers the
// cycle after the last result of the previous one is loaded, even while that
// result still waits to be taken. The store is not cleared at reset and needs
// no clearing pass; only written entries are returned. Slots freed by dequeue
// are reused only after that queue drains and its indices return home.
// ----------------------------------------------------------------------------
module dual_queue_shared_array_unit import dqsa_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dqsa_req_if.sink   req,
  dqsa_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 1);

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  // Sequencer owns the queue indices and the result register.
  dqsa_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .IW    (IW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A write lands at the edge that leaves the execute state, before the next
  // request can read, so no forwarding path is needed between the two ports.
  dqsa_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- design/dqsa_mem.sv -----
// ----------------------------------------------------------------------------
// dqsa_mem
// Shared word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dqsa_mem import dqsa_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // Read data holds between reads so a stalled result can reuse it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/dqsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// dqsa_ctrl
// Sequencer: queue indices, memory access, display walk and result register.
// ----------------------------------------------------------------------------
module dqsa_ctrl import dqsa_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int IW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  dqsa_req_if.sink                 req,
  dqsa_rsp_if.source               rsp,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic signed [DATA_W-1:0] wr_data,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic signed [DATA_W-1:0] rd_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  localparam logic [IW-1:0] TOP = IW'(DEPTH);
  localparam logic [IW-1:0] ONE = IW'(1);

  state_t                   state, state_next;
  op_t                      op, op_next;
  logic                     qsel, qsel_next;
  logic signed [DATA_W-1:0] val, val_next;
  logic [IW-1:0]            cur, cur_next;
  logic [IW-1:0]            a_head, a_head_next, a_end, a_end_next;
  logic [IW-1:0]            b_head, b_head_next, b_end, b_end_next;
  logic                     o_valid, o_valid_next;
  status_t                  o_status, o_status_next;
  logic signed [DATA_W-1:0] o_data, o_data_next;
  logic                     o_last, o_last_next;

  logic accept, slot_free, a_empty, b_empty, walk_last;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign slot_free  = !o_valid || rsp.ready;
  assign a_empty    = (a_head >= a_end);
  assign b_empty    = (b_head <= b_end);
  assign walk_last  = qsel ? (cur == b_end) : ((cur + ONE) == a_end);

  assign rsp.valid  = o_valid;
  assign rsp.status = o_status;
  assign rsp.data   = o_data;
  assign rsp.last   = o_last;

  always_comb begin
    state_next    = state;
    op_next       = op;
    qsel_next     = qsel;
    val_next      = val;
    cur_next      = cur;
    a_head_next   = a_head;
    a_end_next    = a_end;
    b_head_next   = b_head;
    b_end_next    = b_end;
    o_valid_next  = o_valid && !rsp.ready;
    o_status_next = o_status;
    o_data_next   = o_data;
    o_last_next   = o_last;
    wr_en         = 1'b0;
    wr_addr       = a_end[AW-1:0];
    wr_data       = val;
    rd_en         = 1'b0;
    rd_addr       = cur[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          // Start the head read now; the data lands for the execute cycle.
          op_next   = op_t'(req.operation);
          qsel_next = req.queue_select;
          val_next  = req.value;
          cur_next  = req.queue_select ? (b_head - ONE) : a_head;
          rd_en     = 1'b1;
          rd_addr   = cur_next[AW-1:0];
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op)
          OP_ENQ: begin
            if (slot_free) begin
              o_valid_next = 1'b1;
              o_last_next  = 1'b1;
              if (a_end >= b_end) begin
                o_status_next = ST_OVER;
                o_data_next   = '0;
              end else begin
                o_status_next = ST_OK;
                o_data_next   = val;
                wr_en         = 1'b1;
                if (!qsel) begin
                  wr_addr    = a_end[AW-1:0];
                  a_end_next = a_end + ONE;
                end else begin
                  wr_addr    = b_end_next[AW-1:0];
                  b_end_next = b_end - ONE;
                  wr_addr    = b_end_next[AW-1:0];
                end
              end
              state_next = S_IDLE;
            end
          end
          OP_DEQ: begin
            if (slot_free) begin
              o_valid_next = 1'b1;
              o_last_next  = 1'b1;
              if (qsel ? b_empty : a_empty) begin
                o_status_next = ST_UNDER;
                o_data_next   = '0;
              end else begin
                o_status_next = ST_OK;
                o_data_next   = rd_data;
                if (!qsel) begin
                  if ((a_head + ONE) >= a_end) begin
                    a_head_next = '0;
                    a_end_next  = '0;
                  end else begin
                    a_head_next = a_head + ONE;
                  end
                end else begin
                  if ((b_head - ONE) <= b_end) begin
                    b_head_next = TOP;
                    b_end_next  = TOP;
                  end else begin
                    b_head_next = b_head - ONE;
                  end
                end
              end
              state_next = S_IDLE;
            end
          end
          OP_SHOW: begin
            if (slot_free) begin
              o_valid_next = 1'b1;
              if (qsel ? b_empty : a_empty) begin
                o_status_next = ST_EMPTY;
                o_data_next   = '0;
                o_last_next   = 1'b1;
                state_next    = S_IDLE;
              end else begin
                o_status_next = ST_OK;
                o_data_next   = rd_data;
                o_last_next   = walk_last;
                if (walk_last) begin
                  state_next = S_IDLE;
                end else begin
                  // Advance the cursor and fetch the next entry.
                  cur_next = qsel ? (cur - ONE) : (cur + ONE);
                  rd_en    = 1'b1;
                  rd_addr  = cur_next[AW-1:0];
                end
              end
            end
          end
          default: begin
            // Unused code: drop the item, no result.
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      a_head  <= '0;
      a_end   <= '0;
      b_head  <= TOP;
      b_end   <= TOP;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      a_head  <= a_head_next;
      a_end   <= a_end_next;
      b_head  <= b_head_next;
      b_end   <= b_end_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    qsel     <= qsel_next;
    val      <= val_next;
    cur      <= cur_next;
    o_status <= o_status_next;
    o_data   <= o_data_next;
    o_last   <= o_last_next;
  end

endmodule

// ----- design/dqsa_checker.sv -----
// ----------------------------------------------------------------------------
// dqsa_checker
// Port-level checks for the dual queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module dqsa_checker import dqsa_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [1:0]               rsp_status,
  input logic signed [DATA_W-1:0] rsp_data,
  input logic                     rsp_last
);

  // Hold a pending result until its transfer.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status))
    else $error("response changed while stalled");

  // Error and empty results carry zero data and close the run.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_data == '0) && rsp_last)
    else $error("error result with data or without last");

  // One request at a time: no transfer in the cycle after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind dual_queue_shared_array_unit dqsa_checker u_dqsa_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_data   (rsp.data),
  .rsp_last   (rsp.last)
);

// ----- tb/sv/dual_queue_shared_array_unit_test.sv -----
// ----------------------------------------------------------------------------
// dual_queue_shared_array_unit_test
// Self-checking bench for the two-queue shared store: a directed table of
// corner cases, then biased random bursts, all scored against a shadow copy
// of both queues kept inside the bench.
// ----------------------------------------------------------------------------
module dual_queue_shared_array_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dqsa_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 280;
  localparam int QUIET_ITEMS  = 40;
  localparam int TAIL_CYCLES  = 40;

  // One result word as it leaves the block.
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } dq_result_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    op_t               op;
    logic              qsel;
    logic [DATA_W-1:0] word;
    bit                typed;
    dq_result_t        want;
  } dir_row_t;

  // Random bursts lean toward one kind of traffic each.
  typedef enum int {
    MODE_FILL_A,
    MODE_FILL_B,
    MODE_DRAIN,
    MODE_SHOW,
    MODE_MIX
  } burst_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dqsa_req_if req ();
  dqsa_rsp_if rsp ();

  dual_queue_shared_array_unit #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the block: store contents plus the four queue indices.
  // A holds shadow_mem[a_rd .. a_wr-1], head at a_rd.
  // B holds shadow_mem[b_wr .. b_rd-1], head at b_rd-1.
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] shadow_mem [DEPTH];
  int                       a_rd;
  int                       a_wr;
  int                       b_rd;
  int                       b_wr;

  dq_result_t fresh_results [$];    // results of the request just transferred
  dq_result_t pending_results [$];  // results still owed by the block

  bit         row_typed;            // current request carries a hand-typed answer
  dq_result_t row_want;
  bit         quiet;                // no idling on either side
  int         error_count;

  function automatic void note_result(status_t st, logic signed [DATA_W-1:0] d,
                                      logic lst);
    dq_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    fresh_results.push_back(r);
  endfunction

  // Advance the shadow by one request and collect what the block must return.
  function automatic void model_request(logic [1:0] op, logic qsel,
                                        logic signed [DATA_W-1:0] word);
    int i;
    fresh_results.delete();
    case (op)
      OP_ENQ: begin
        // Full once the free ends of the two queues meet.
        if (a_wr >= b_wr) begin
          note_result(ST_OVER, '0, 1'b1);
        end else if (!qsel) begin
          shadow_mem[a_wr] = word;
          a_wr++;
          note_result(ST_OK, word, 1'b1);
        end else begin
          b_wr--;
          shadow_mem[b_wr] = word;
          note_result(ST_OK, word, 1'b1);
        end
      end
      OP_DEQ: begin
        if (!qsel) begin
          if (a_rd >= a_wr) begin
            note_result(ST_UNDER, '0, 1'b1);
          end else begin
            note_result(ST_OK, shadow_mem[a_rd], 1'b1);
            a_rd++;
            // Drained: send both indices home.
            if (a_rd >= a_wr) begin
              a_rd = 0;
              a_wr = 0;
            end
          end
        end else begin
          if (b_rd <= b_wr) begin
            note_result(ST_UNDER, '0, 1'b1);
          end else begin
            b_rd--;
            note_result(ST_OK, shadow_mem[b_rd], 1'b1);
            if (b_rd <= b_wr) begin
              b_rd = DEPTH;
              b_wr = DEPTH;
            end
          end
        end
      end
      OP_SHOW: begin
        if (!qsel) begin
          if (a_rd >= a_wr) begin
            note_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = a_rd; i < a_wr; i++) begin
              note_result(ST_OK, shadow_mem[i], i + 1 == a_wr);
            end
          end
        end else begin
          if (b_rd <= b_wr) begin
            note_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = b_rd; i > b_wr; i--) begin
              note_result(ST_OK, shadow_mem[i - 1], i - 1 == b_wr);
            end
          end
        end
      end
      default: begin
        // Unused code: the block drops the request, nothing comes back.
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Check the response transfer first, then book the request
  // transfer of the same edge; a request never answers in its own cycle, so
  // the oldest pending entry always belongs to an earlier request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    dq_result_t want;
    if (rst) begin
      a_rd = 0;
      a_wr = 0;
      b_rd = DEPTH;
      b_wr = DEPTH;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: status=%0d data=%h last=%b",
                   $time, rsp.status, rsp.data, rsp.last);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status || rsp.data !== want.data ||
              rsp.last !== want.last) begin
            $display("%0t: mismatch: expected status=%0d data=%h last=%b, got status=%0d data=%h last=%b",
                     $time, want.status, want.data, want.last,
                     rsp.status, rsp.data, rsp.last);
            error_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        model_request(req.operation, req.queue_select, req.value);
        // Hand-typed rows replace the shadow's answer; the shadow still advances.
        if (row_typed) begin
          pending_results.push_back(row_want);
        end else begin
          foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: ready drops at random times, and stall windows switch on
  // and off so that some stretches run without any back-pressure.
  // --------------------------------------------------------------------------
  initial begin : rsp_drive
    int  cycle;
    bit  stall_on;
    rsp.ready = 1'b0;
    cycle     = 0;
    stall_on  = 1'b1;
    forever begin
      @(negedge clk);
      if (cycle % 64 == 0) stall_on = ($urandom_range(0, 2) != 0);
      cycle++;
      if (!quiet && stall_on && $urandom_range(0, 3) == 0) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      rsp.ready = 1'b1;
    end
  end

  // Present one request from a falling edge on and hold it until it transfers;
  // return at the falling edge after the transfer.
  task automatic send_item(input op_t op, input logic qsel, input logic [DATA_W-1:0] word,
                           input bit typed, input dq_result_t want, input int idle_pct);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req.valid        = 1'b1;
    req.operation    = op;
    req.queue_select = qsel;
    req.value        = word;
    row_typed        = typed;
    row_want         = want;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Hold off the request side until the block owes nothing.
  task automatic await_drain();
    req.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  dir_row_t dir_rows [$];

  task automatic add_row(input op_t op, input logic qsel, input logic [DATA_W-1:0] word,
                         input bit typed, input status_t st, input logic [DATA_W-1:0] d);
    dir_row_t row;
    row.op          = op;
    row.qsel        = qsel;
    row.word        = word;
    row.typed       = typed;
    row.want.status = st;
    row.want.data   = d;
    row.want.last   = 1'b1;
    dir_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then random bursts, then the drain at the end.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    burst_mode_t       mode;
    dq_result_t        none_want;
    op_t               op;
    logic              qsel;
    logic [DATA_W-1:0] word;
    int                real_items;
    int                burst;
    int                len;
    int                idle_pct;
    int                enq_pct;
    int                deq_pct;
    int                a_pct;
    int                roll;

    req.valid        = 1'b0;
    req.operation    = OP_ENQ;
    req.queue_select = 1'b0;
    req.value        = '0;
    row_typed        = 1'b0;
    none_want        = '0;
    row_want         = none_want;
    quiet            = 1'b0;
    error_count      = 0;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Empty queues right after reset, data extremes, drain and return home,
    // the unused code, and a refill of B after it went home.
    add_row(OP_DEQ,  1'b0, 32'h0000_0000, 1'b1, ST_UNDER, 32'h0000_0000);
    add_row(OP_DEQ,  1'b1, 32'hFFFF_FFFF, 1'b1, ST_UNDER, 32'h0000_0000);
    add_row(OP_SHOW, 1'b0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000);
    add_row(OP_SHOW, 1'b1, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000);
    add_row(OP_ENQ,  1'b0, 32'h7FFF_FFFF, 1'b1, ST_OK,    32'h7FFF_FFFF);
    add_row(OP_ENQ,  1'b0, 32'h8000_0000, 1'b1, ST_OK,    32'h8000_0000);
    add_row(OP_ENQ,  1'b1, 32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000);
    add_row(OP_ENQ,  1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'hFFFF_FFFF);
    add_row(OP_SHOW, 1'b0, 32'hFFFF_FFFF, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_SHOW, 1'b1, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_NONE, 1'b0, 32'h5A5A_5A5A, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_DEQ,  1'b0, 32'hFFFF_FFFF, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_DEQ,  1'b1, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_ENQ,  1'b0, 32'h1234_5678, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_DEQ,  1'b0, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_DEQ,  1'b0, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_DEQ,  1'b0, 32'h0000_0000, 1'b1, ST_UNDER, 32'h0000_0000);
    add_row(OP_SHOW, 1'b0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000);
    add_row(OP_DEQ,  1'b1, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_SHOW, 1'b1, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000);
    add_row(OP_NONE, 1'b1, 32'hFFFF_FFFF, 1'b0, ST_OK,    32'h0000_0000);
    add_row(OP_ENQ,  1'b1, 32'hA5A5_A5A5, 1'b1, ST_OK,    32'hA5A5_A5A5);
    add_row(OP_SHOW, 1'b1, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].qsel, dir_rows[i].word,
                dir_rows[i].typed, dir_rows[i].want, 30);
    end

    // Random bursts. The first leans toward filling A, the second toward shows;
    // later bursts pick their bias at random. Unused codes are noise and do
    // not count toward the item total.
    real_items = 0;
    burst      = 0;
    while (real_items < RANDOM_ITEMS) begin
      case (burst)
        0:       mode = MODE_FILL_A;
        1:       mode = MODE_SHOW;
        default: mode = burst_mode_t'($urandom_range(0, 4));
      endcase
      len      = $urandom_range(8, 24);
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
      // Let the block run dry now and then, always once early on.
      if (burst == 2 || (burst > 2 && $urandom_range(0, 3) == 0)) await_drain();
      case (mode)
        MODE_FILL_A: begin enq_pct = 70; deq_pct = 12; a_pct = 85; end
        MODE_FILL_B: begin enq_pct = 70; deq_pct = 12; a_pct = 15; end
        MODE_DRAIN:  begin enq_pct = 10; deq_pct = 75; a_pct = 50; end
        MODE_SHOW:   begin enq_pct = 30; deq_pct = 20; a_pct = 50; end
        default:     begin enq_pct = 32; deq_pct = 33; a_pct = 50; end
      endcase
      for (int k = 0; k < len && real_items < RANDOM_ITEMS; k++) begin
        quiet = (real_items >= RANDOM_ITEMS - QUIET_ITEMS);
        roll  = $urandom_range(0, 99);
        if (roll < 3)                      op = OP_NONE;
        else if (roll < 3 + enq_pct)       op = OP_ENQ;
        else if (roll < 3 + enq_pct + deq_pct) op = OP_DEQ;
        else                               op = OP_SHOW;
        qsel = ($urandom_range(0, 99) >= a_pct);
        case ($urandom_range(0, 19))
          0:       word = 32'h7FFF_FFFF;
          1:       word = 32'h8000_0000;
          2:       word = 32'h0000_0000;
          3:       word = 32'hFFFF_FFFF;
          default: word = $urandom;
        endcase
        send_item(op, qsel, word, 1'b0, none_want, idle_pct);
        if (op != OP_NONE) real_items++;
      end
      burst++;
    end

    // Drop valid, wait for every owed result, then give the block time to
    // show anything it should not send.
    await_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout, %0d results still owed", $time, pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
